[hdl/rrw_pkg.sv]
// shared types and codes for the receive reorder window
package rrw_pkg;

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_SKIP  = 2'd2,
    ACT_RESET = 2'd3
  } action_t;

  localparam logic ST_DONE   = 1'b0;
  localparam logic ST_REJECT = 1'b1;

  typedef struct packed {
    action_t     action;
    logic [31:0] seq_num;
    logic [63:0] entry_data;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [63:0] popped_data;
    logic [31:0] popped_seq;
    logic        nack_needed;
    logic [31:0] nack_seq;
  } out_item_t;

endpackage

[hdl/rrw_slot_div.sv]
// pipelined seq_num mod SLOTS by reciprocal multiply, carries the beat alongside
module rrw_slot_div #(
  parameter int SLOTS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_vld,
  input  rrw_pkg::in_item_t     in_item,
  output logic                  out_vld,
  output rrw_pkg::in_item_t     out_item,
  output logic [$clog2(SLOTS)-1:0] out_sidx
);
  import rrw_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);
  localparam int REM_W = IDX_W + 1;
  localparam int SHIFT = 32 + IDX_W;
  // floor(2^SHIFT / SLOTS): quotient comes out exact or one low
  localparam logic [32:0] RECIP = 33'((64'd1 << SHIFT) / 64'(SLOTS));

  logic              vld_a_r, vld_b_r, vld_c_r;
  in_item_t          item_a_r, item_b_r, item_c_r;
  logic [31:0]       quot_b_r;
  logic [REM_W-1:0]  rem_c_r;

  logic [64:0]       recip_prod;
  logic [31:0]       quot_nxt;
  logic [42:0]       back_prod;
  logic [42:0]       diff;
  logic [REM_W-1:0]  rem_nxt;

  always_comb begin
    recip_prod = 65'(item_a_r.seq_num) * 65'(RECIP);
    quot_nxt   = 32'(recip_prod >> SHIFT);
    back_prod  = 43'(quot_b_r) * 43'(SLOTS);
    diff       = 43'(item_b_r.seq_num) - back_prod;
    rem_nxt    = REM_W'(diff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      vld_c_r <= 1'b0;
    end else begin
      vld_a_r <= in_vld;
      vld_b_r <= vld_a_r;
      vld_c_r <= vld_b_r;
    end
    item_a_r <= in_item;
    item_b_r <= item_a_r;
    quot_b_r <= quot_nxt;
    item_c_r <= item_b_r;
    rem_c_r  <= rem_nxt;
  end

  // one correction step covers a low quotient
  assign out_sidx = (rem_c_r >= REM_W'(SLOTS)) ? IDX_W'(rem_c_r - REM_W'(SLOTS))
                                               : IDX_W'(rem_c_r);
  assign out_vld  = vld_c_r;
  assign out_item = item_c_r;

endmodule

[hdl/receive_reorder_window_top.sv]
// receive reorder window: slot state, descriptor store and result register
// a beat passes divider stages a, b and c, then the result register, before its strobe
// throughput: one beat per cycle while busy is low, set by the slot read-modify-write
// the receiver cannot stall; each result is strobed for exactly one cycle
// reset clears slot valid bits, held count and the expected number; busy is high
// until the cycle after reset; the descriptor store is not cleared
module receive_reorder_window_top #(
  parameter int SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  rrw_pkg::in_item_t  in_item,
  output logic               out_strobe,
  output rrw_pkg::out_item_t out_item
);
  import rrw_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);

  logic             busy_r;
  logic             ex_vld;
  in_item_t         ex_item;
  logic [IDX_W-1:0] ex_sidx;

  logic [31:0]      exp_r, exp_nxt;
  logic [IDX_W-1:0] exp_idx_r, exp_idx_nxt, exp_idx_inc;
  logic [SLOTS-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0] held_r, held_nxt;
  logic [63:0]      head_data_r;
  logic [63:0]      slot_mem [SLOTS];

  logic             out_strobe_r;
  out_item_t        out_item_r, out_item_nxt;

  logic             wr_en;
  logic [31:0]      win_diff;
  logic             nack;

  rrw_slot_div #(.SLOTS(SLOTS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (start && !busy_r),
    .in_item  (in_item),
    .out_vld  (ex_vld),
    .out_item (ex_item),
    .out_sidx (ex_sidx)
  );

  always_comb begin
    // the number wraps past 2^32 back to slot zero
    exp_idx_inc  = ((exp_r == 32'hFFFF_FFFF) || (exp_idx_r == IDX_W'(SLOTS - 1)))
                   ? '0 : exp_idx_r + 1'b1;
    win_diff     = ex_item.seq_num - exp_r;
    exp_nxt      = exp_r;
    exp_idx_nxt  = exp_idx_r;
    valid_nxt    = valid_r;
    held_nxt     = held_r;
    wr_en        = 1'b0;
    out_item_nxt = '0;
    if (ex_vld) begin
      unique case (ex_item.action)
        ACT_PUSH: begin
          if (win_diff < 32'(SLOTS)) begin
            if (!valid_r[ex_sidx]) begin
              wr_en              = 1'b1;
              valid_nxt[ex_sidx] = 1'b1;
              held_nxt           = held_r + 1'b1;
            end
          end else begin
            out_item_nxt.status = ST_REJECT;
          end
        end
        ACT_POP: begin
          if (valid_r[exp_idx_r]) begin
            out_item_nxt.popped_data = head_data_r;
            out_item_nxt.popped_seq  = exp_r;
            valid_nxt[exp_idx_r]     = 1'b0;
            held_nxt                 = held_r - 1'b1;
            exp_nxt                  = exp_r + 32'd1;
            exp_idx_nxt              = exp_idx_inc;
          end else begin
            out_item_nxt.status = ST_REJECT;
          end
        end
        ACT_SKIP: begin
          if (ex_item.seq_num == exp_r) begin
            // skipped number maps to the head slot
            if (valid_r[exp_idx_r]) begin
              valid_nxt[exp_idx_r] = 1'b0;
              held_nxt             = held_r - 1'b1;
            end
            exp_nxt     = exp_r + 32'd1;
            exp_idx_nxt = exp_idx_inc;
          end else begin
            out_item_nxt.status = ST_REJECT;
          end
        end
        ACT_RESET: begin
          valid_nxt   = '0;
          held_nxt    = '0;
          exp_nxt     = ex_item.seq_num;
          exp_idx_nxt = ex_sidx;
        end
        default: begin
          out_item_nxt.status = ST_REJECT;
        end
      endcase
    end
    nack                     = !valid_nxt[exp_idx_nxt] && (held_nxt != '0);
    out_item_nxt.nack_needed = nack;
    out_item_nxt.nack_seq    = nack ? exp_nxt : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b1;
      exp_r        <= '0;
      exp_idx_r    <= '0;
      valid_r      <= '0;
      held_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      busy_r       <= 1'b0;
      exp_r        <= exp_nxt;
      exp_idx_r    <= exp_idx_nxt;
      valid_r      <= valid_nxt;
      held_r       <= held_nxt;
      out_strobe_r <= ex_vld;
    end
    out_item_r <= out_item_nxt;
  end

  // descriptor store; head register follows the slot of the next expected number
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[ex_sidx] <= ex_item.entry_data;
    end
    if (wr_en && (ex_sidx == exp_idx_nxt)) begin
      head_data_r <= ex_item.entry_data;
    end else begin
      head_data_r <= slot_mem[exp_idx_nxt];
    end
  end

  assign busy       = busy_r;
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  a_held_count: assert property (@(posedge clk) disable iff (!rst_n)
    held_r == CNT_W'($countones(valid_r)))
    else $error("held count disagrees with valid slots");

  a_nack_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r && out_item_r.nack_needed |->
      (out_item_r.nack_seq == exp_r) && !valid_r[exp_idx_r])
    else $error("nack does not match window state");

  a_pop_advance: assert property (@(posedge clk) disable iff (!rst_n)
    ex_vld && (ex_item.action == ACT_POP) && valid_r[exp_idx_r] |=>
      (exp_r == $past(exp_r) + 32'd1) && !valid_r[$past(exp_idx_r)])
    else $error("pop did not advance the window");

endmodule

[verif/receive_reorder_window_top_test.sv]
// self-checking testbench for the receive reorder window top level
module receive_reorder_window_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rrw_pkg::*;

  localparam int SLOTS = 16;
  localparam int QUIET_LIMIT = 500;
  localparam int RANDOM_BEATS = 500;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_PRINTED = 40;

  // window contents as the predictor sees them
  typedef struct packed {
    logic [31:0]            base;
    logic [SLOTS-1:0]       valid;
    logic [SLOTS-1:0][63:0] desc;
  } window_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_strobe;
  out_item_t out_item;

  in_item_t  pending_beats[$];
  out_item_t expected_results[$];
  window_t   plan_window;
  window_t   check_window;
  logic      beat_taken = 1'b0;
  int        idle_left = 0;
  logic      steady_run = 1'b0;
  int        quiet_cycles = 0;
  int        mismatches = 0;

  receive_reorder_window_top #(.SLOTS(SLOTS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  always #6 clk = ~clk;

  // one beat through the window: updates the state and returns the result
  task automatic window_step(inout window_t w, input in_item_t b, output out_item_t r);
    logic [31:0] gap;
    int unsigned idx;
    r = '0;
    r.status = ST_DONE;
    gap = b.seq_num - w.base;
    case (b.action)
      ACT_PUSH: begin
        if (gap < SLOTS) begin
          idx = b.seq_num % SLOTS;
          // duplicate keeps the held descriptor
          if (!w.valid[idx]) begin
            w.valid[idx] = 1'b1;
            w.desc[idx] = b.entry_data;
          end
        end else begin
          r.status = ST_REJECT;
        end
      end
      ACT_POP: begin
        idx = w.base % SLOTS;
        if (w.valid[idx]) begin
          r.popped_data = w.desc[idx];
          r.popped_seq = w.base;
          w.valid[idx] = 1'b0;
          w.base = w.base + 1;
        end else begin
          r.status = ST_REJECT;
        end
      end
      ACT_SKIP: begin
        if (b.seq_num == w.base) begin
          w.valid[w.base % SLOTS] = 1'b0;
          w.base = w.base + 1;
        end else begin
          r.status = ST_REJECT;
        end
      end
      default: begin
        w.valid = '0;
        w.base = b.seq_num;
      end
    endcase
    if (!w.valid[w.base % SLOTS] && w.valid != '0) begin
      r.nack_needed = 1'b1;
      r.nack_seq = w.base;
    end
  endtask

  task automatic queue_beat(input action_t act, input logic [31:0] seq,
                            input logic [63:0] data);
    in_item_t  b;
    out_item_t unused;
    b.action = act;
    b.seq_num = seq;
    b.entry_data = data;
    window_step(plan_window, b, unused);
    pending_beats.push_back(b);
  endtask

  task automatic flag_mismatch(input string what);
    if (mismatches < MAX_PRINTED)
      $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic logic [63:0] pick_desc();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  // driver: beats change on the falling edge, held until accepted
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !beat_taken) begin
      // hold the beat
    end else if (idle_left > 0) begin
      start <= 1'b0;
      idle_left <= idle_left - 1;
    end else if (pending_beats.size() > 0) begin
      in_item <= pending_beats.pop_front();
      start <= 1'b1;
      if ($urandom_range(0, 49) == 0)
        steady_run <= ~steady_run;
      if (steady_run)
        idle_left <= 0;
      else if ($urandom_range(0, 9) < 6)
        idle_left <= 0;
      else if ($urandom_range(0, 9) < 8)
        idle_left <= $urandom_range(1, 3);
      else
        idle_left <= $urandom_range(10, 40);
    end else begin
      start <= 1'b0;
    end
  end

  // monitor: predicts on each accepted beat and checks each strobed result
  always @(posedge clk) begin
    out_item_t predicted;
    out_item_t want;
    beat_taken <= start && !busy;
    if (rst_n && out_strobe) begin
      if (expected_results.size() == 0) begin
        flag_mismatch("result strobed with nothing expected");
      end else begin
        want = expected_results.pop_front();
        if (out_item.status !== want.status)
          flag_mismatch($sformatf("status %b, want %b", out_item.status, want.status));
        if (out_item.popped_data !== want.popped_data)
          flag_mismatch($sformatf("popped_data %h, want %h",
                                  out_item.popped_data, want.popped_data));
        if (out_item.popped_seq !== want.popped_seq)
          flag_mismatch($sformatf("popped_seq %h, want %h",
                                  out_item.popped_seq, want.popped_seq));
        if (out_item.nack_needed !== want.nack_needed)
          flag_mismatch($sformatf("nack_needed %b, want %b",
                                  out_item.nack_needed, want.nack_needed));
        if (out_item.nack_seq !== want.nack_seq)
          flag_mismatch($sformatf("nack_seq %h, want %h",
                                  out_item.nack_seq, want.nack_seq));
      end
    end
    if (rst_n && start && !busy) begin
      window_step(check_window, in_item, predicted);
      expected_results.push_back(predicted);
    end
  end

  // watchdog on cycles with no beat in either direction
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_strobe) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("** receive_reorder_window_top: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned pick;
    logic [31:0] b;
    plan_window = '0;
    check_window = '0;

    // directed: window edges, duplicates, wrong skips, wrap across 2^32
    queue_beat(ACT_RESET, 32'd0, '0);
    queue_beat(ACT_POP, 32'd0, '0);
    queue_beat(ACT_PUSH, 32'd0, '1);
    queue_beat(ACT_POP, 32'hFFFF_FFFF, '1);
    queue_beat(ACT_PUSH, 32'd16, 64'h0);
    queue_beat(ACT_PUSH, 32'd17, 64'h1);
    queue_beat(ACT_PUSH, 32'd0, 64'h2);
    queue_beat(ACT_PUSH, 32'd5, 64'h5555_AAAA_5555_AAAA);
    queue_beat(ACT_PUSH, 32'd5, 64'hAAAA_5555_AAAA_5555);
    queue_beat(ACT_POP, 32'd0, '0);
    queue_beat(ACT_SKIP, 32'd3, '0);
    queue_beat(ACT_SKIP, 32'd1, '0);
    queue_beat(ACT_PUSH, 32'd2, 64'hDEAD_BEEF_0123_4567);
    queue_beat(ACT_SKIP, 32'd2, '0);
    queue_beat(ACT_RESET, 32'hFFFF_FFF8, '1);
    queue_beat(ACT_PUSH, 32'hFFFF_FFFF, '1);
    queue_beat(ACT_PUSH, 32'd0, 64'h8000_0000_0000_0001);
    queue_beat(ACT_PUSH, 32'd7, 64'h7FFF_FFFF_FFFF_FFFE);
    queue_beat(ACT_PUSH, 32'd8, '1);
    queue_beat(ACT_SKIP, 32'hFFFF_FFF8, '0);
    queue_beat(ACT_POP, '1, '1);
    queue_beat(ACT_RESET, 32'hFFFF_FFFF, '0);
    queue_beat(ACT_PUSH, 32'hFFFF_FFFF, '1);
    queue_beat(ACT_POP, 32'd0, '0);
    queue_beat(ACT_POP, 32'd0, '0);

    // random: mostly in-window traffic, some noise and window moves
    repeat (RANDOM_BEATS) begin
      b = plan_window.base;
      pick = $urandom_range(0, 99);
      if (pick < 45)
        queue_beat(ACT_PUSH, b + $urandom_range(0, SLOTS - 1), pick_desc());
      else if (pick < 70)
        queue_beat(ACT_POP, $urandom, pick_desc());
      else if (pick < 78)
        queue_beat(ACT_SKIP, b, pick_desc());
      else if (pick < 81)
        queue_beat(ACT_SKIP, b + $urandom_range(1, 40), pick_desc());
      else if (pick < 85)
        queue_beat(ACT_PUSH, b + SLOTS + $urandom_range(0, 200), pick_desc());
      else if (pick < 88)
        queue_beat(ACT_PUSH, b - 1 - $urandom_range(0, 200), pick_desc());
      else if (pick < 93)
        queue_beat(ACT_PUSH, $urandom, pick_desc());
      else if (pick < 95)
        queue_beat(ACT_RESET, $urandom, pick_desc());
      else if (pick < 97)
        queue_beat(ACT_RESET, 32'hFFFF_FFFF - $urandom_range(0, 20), pick_desc());
      else
        queue_beat(ACT_RESET, $urandom_range(0, 20), pick_desc());
    end

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    while (pending_beats.size() > 0 || start) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("** receive_reorder_window_top: PASSED **");
    else
      $display("** receive_reorder_window_top: FAILED **");
    $finish;
  end

endmodule
